### rtl/ormu_pkg.sv
// ----------------------------------------------------------------------------
// ormu_pkg
// Shared constants and types for the outlier rejecting rate mean unit.
// ----------------------------------------------------------------------------
package ormu_pkg;

    localparam int DEPTH_DEF       = 10;
    localparam int SAMPLE_BITS_DEF = 16;

    // multiplier digit size and divide/root operand width
    localparam int MUL_DIGIT = 16;
    localparam int DS_WIDTH  = 64;

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 8;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_WARM_MULT     = 2'd0,
        REG_RUN_MULT      = 2'd1,
        REG_BAND_FRACTION = 2'd2,
        REG_EMA_WEIGHT    = 2'd3
    } cfg_reg_t;

    localparam logic [3:0] WARM_MULT_RST     = 4'd2;
    localparam logic [3:0] RUN_MULT_RST      = 4'd4;
    localparam logic [7:0] BAND_FRACTION_RST = 8'd102;
    localparam logic [7:0] EMA_WEIGHT_RST    = 8'd26;

    typedef enum logic {
        DS_DIV  = 1'b0,
        DS_SQRT = 1'b1
    } ds_mode_t;

    typedef struct packed {
        logic     start;
        ds_mode_t mode;
    } ds_ctl_t;

endpackage

### rtl/outlier_rejecting_rate_mean_unit.sv
// ----------------------------------------------------------------------------
// outlier_rejecting_rate_mean_unit
// Filtered rate mean with warm-up outlier rejection and tracking bounds.
//
//  port group   dir  fields (low bit up)
//  s_*          in   tdata: sample[15:0]
//  m_*          out  tdata: filtered_mean[15:0]; tuser: sample_taken[0]
//  cfg_*        in   write: warm_mult, run_mult, band_fraction, ema_weight
//
// One request at a time, sequenced over a shared multiplier and a shared
// divide/root unit. Warm-up requests take a multiply and one 64-step
// divide; the request that fills the buffer adds DEPTH squaring passes, a
// 64-step divide, a 32-step root and a scan of all DEPTH entries. Tracking
// requests in bounds run two EMA multiplies and the same deviation, root and
// limit passes; rejected ones go straight to the output. Reset is synchronous
// and needs no clearing pass; a held result stalls only the final write-back of the next request.
// ----------------------------------------------------------------------------
module outlier_rejecting_rate_mean_unit import ormu_pkg::*; #(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [15:0]              s_tdata,   // sample
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [15:0]              m_tdata,   // filtered_mean
    output logic [0:0]               m_tuser,   // sample_taken
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

    localparam int SB  = SAMPLE_BITS;
    localparam int MW  = SB + 8;
    localparam int PW  = 2 * MW;
    localparam int LW  = SB + 10;
    localparam int LXW = SB + 12;
    localparam int HB  = SB + 11;
    localparam int AC  = SB + 6;
    localparam int IW  = $clog2(DEPTH);
    localparam int CW  = $clog2(DEPTH + 1);

    localparam logic signed [LXW-1:0] LIM_HI = {3'b000, {(SB+9){1'b1}}};
    localparam logic signed [LXW-1:0] LIM_LO = {3'b111, {(SB+9){1'b0}}};
    localparam logic [HB-1:0]         HCAP   = {1'b1, {(SB+10){1'b0}}};
    localparam logic [CW-1:0]         DEPTH_C = CW'(DEPTH);
    localparam logic [IW-1:0]         LAST_IX = IW'(DEPTH - 1);

    typedef enum logic [14:0] {
        ST_IDLE     = 15'h0001,
        ST_WM_MUL   = 15'h0002,
        ST_WM_DIV   = 15'h0004,
        ST_DEV_MUL  = 15'h0008,
        ST_DEV_DIV  = 15'h0010,
        ST_DEV_SQRT = 15'h0020,
        ST_LIM_MUL  = 15'h0040,
        ST_BAND_MUL = 15'h0080,
        ST_LIM_SET  = 15'h0100,
        ST_SCAN     = 15'h0200,
        ST_SUM      = 15'h0400,
        ST_REDIV    = 15'h0800,
        ST_EMA1     = 15'h1000,
        ST_EMA2     = 15'h2000,
        ST_OUT      = 15'h4000
    } state_t;

    state_t state_reg, state_next;

    logic [SB-1:0]  store_reg [DEPTH];
    logic [SB-1:0]  store_next [DEPTH];
    logic [CW-1:0]  fill_reg, fill_next;
    logic           tracking_reg, tracking_next;
    logic [IW-1:0]  ptr_reg, ptr_next;
    logic [MW-1:0]  mean_reg, mean_next;
    logic signed [LW-1:0] lower_reg, lower_next;
    logic signed [LW-1:0] upper_reg, upper_next;
    logic [SB-1:0]  smp_reg, smp_next;
    logic           taken_reg, taken_next;
    logic [IW-1:0]  idx_reg, idx_next;
    logic [63:0]    sum_reg, sum_next;
    logic [AC-1:0]  acc_reg, acc_next;
    logic [63:0]    tmp_reg, tmp_next;
    logic [MW-1:0]  dev_reg, dev_next;
    logic [HB-1:0]  half_reg, half_next;
    logic           issued_reg, issued_next;
    logic           mvalid_reg, mvalid_next;
    logic [15:0]    mmean_reg, mmean_next;
    logic           mtaken_reg, mtaken_next;

    logic [3:0]     warm_mult_reg, run_mult_reg;
    logic [7:0]     band_reg, ema_reg;

    logic           mul_start, mul_done;
    logic [MW-1:0]  mul_a, mul_b;
    logic [PW-1:0]  mul_prod;
    ds_ctl_t        ds_ctl;
    logic [63:0]    ds_x, ds_res;
    logic [CW-1:0]  ds_d;
    logic           ds_done;

    logic [SB-1:0]  s_in;
    logic [SB-1:0]  rd;
    logic [MW-1:0]  rd_x, abs_dev;
    logic signed [LXW-1:0] v_in, v_rd, lo_ext, up_ext;
    logic signed [LXW-1:0] m_s, h_s, lo_raw, hi_raw;
    logic [64:0]    sum_add;
    logic           rd_out;
    logic [CW-1:0]  fill_sc;
    logic [HB-1:0]  bpart;

    function automatic logic [HB-1:0] sat_half(input logic [PW+7:0] x);
        if (x >= (PW+8)'(HCAP)) begin
            return HCAP;
        end
        return HB'(x);
    endfunction

    function automatic logic signed [LW-1:0] clamp_lim(input logic signed [LXW-1:0] x);
        if (x > LIM_HI) begin
            return LW'(LIM_HI);
        end
        if (x < LIM_LO) begin
            return LW'(LIM_LO);
        end
        return LW'(x);
    endfunction

    ormu_mul #(.AW(MW), .BW(MW)) u_mul (
        .aclk(aclk), .aresetn(aresetn), .start(mul_start),
        .a(mul_a), .b(mul_b), .done(mul_done), .prod(mul_prod)
    );

    ormu_divsqrt #(.DW(CW)) u_ds (
        .aclk(aclk), .aresetn(aresetn), .ctl(ds_ctl),
        .x(ds_x), .d(ds_d), .done(ds_done), .res(ds_res)
    );

    assign s_in   = SB'(s_tdata);
    assign rd     = store_reg[idx_reg];
    assign rd_x   = {rd, 8'b0};
    assign abs_dev = (rd_x >= mean_reg) ? (rd_x - mean_reg) : (mean_reg - rd_x);
    assign v_in   = $signed(LXW'({s_in, 8'b0}));
    assign v_rd   = $signed(LXW'(rd_x));
    assign lo_ext = LXW'(lower_reg);
    assign up_ext = LXW'(upper_reg);
    assign rd_out = (v_rd > up_ext) || (v_rd < lo_ext);
    assign m_s    = $signed(LXW'(mean_reg));
    assign h_s    = $signed(LXW'(half_reg));
    assign lo_raw = m_s - h_s;
    assign hi_raw = m_s + h_s;
    assign sum_add = 65'(sum_reg) + 65'(64'(mul_prod >> 16));
    assign fill_sc = fill_reg - CW'(rd_out);
    assign bpart  = sat_half((PW+8)'(mul_prod >> 8));

    // operand selection for the shared units
    always_comb begin
        mul_a       = '0;
        mul_b       = '0;
        mul_start   = 1'b0;
        ds_ctl      = '{start: 1'b0, mode: DS_DIV};
        ds_x        = '0;
        ds_d        = '0;
        unique case (state_reg)
            ST_WM_MUL: begin
                mul_a = mean_reg;
                mul_b = MW'(fill_reg - 1'b1);
                mul_start = !issued_reg;
            end
            ST_DEV_MUL: begin
                mul_a = abs_dev;
                mul_b = abs_dev;
                mul_start = !issued_reg;
            end
            ST_LIM_MUL: begin
                mul_a = dev_reg;
                mul_b = MW'(tracking_reg ? run_mult_reg : warm_mult_reg);
                mul_start = !issued_reg;
            end
            ST_BAND_MUL: begin
                mul_a = MW'(band_reg);
                mul_b = mean_reg;
                mul_start = !issued_reg;
            end
            ST_EMA1: begin
                mul_a = {smp_reg, 8'b0};
                mul_b = MW'(ema_reg);
                mul_start = !issued_reg;
            end
            ST_EMA2: begin
                mul_a = mean_reg;
                mul_b = MW'(9'd256 - 9'(ema_reg));
                mul_start = !issued_reg;
            end
            ST_WM_DIV: begin
                ds_x = tmp_reg;
                ds_d = fill_reg;
                ds_ctl.start = !issued_reg;
            end
            ST_DEV_DIV: begin
                ds_x = sum_reg;
                ds_d = DEPTH_C;
                ds_ctl.start = !issued_reg;
            end
            ST_DEV_SQRT: begin
                ds_x = tmp_reg;
                ds_ctl = '{start: !issued_reg, mode: DS_SQRT};
            end
            ST_REDIV: begin
                ds_x = 64'({acc_reg, 8'b0});
                ds_d = fill_reg;
                ds_ctl.start = !issued_reg;
            end
            ST_IDLE, ST_LIM_SET, ST_SCAN, ST_SUM, ST_OUT: begin
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        store_next    = store_reg;
        fill_next     = fill_reg;
        tracking_next = tracking_reg;
        ptr_next      = ptr_reg;
        mean_next     = mean_reg;
        lower_next    = lower_reg;
        upper_next    = upper_reg;
        smp_next      = smp_reg;
        taken_next    = taken_reg;
        idx_next      = idx_reg;
        sum_next      = sum_reg;
        acc_next      = acc_reg;
        tmp_next      = tmp_reg;
        dev_next      = dev_reg;
        half_next     = half_reg;
        issued_next   = issued_reg;
        mvalid_next   = mvalid_reg && !m_tready;
        mmean_next    = mmean_reg;
        mtaken_next   = mtaken_reg;

        if (mul_start || ds_ctl.start) begin
            issued_next = 1'b1;
        end
        if (mul_done || ds_done) begin
            issued_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    smp_next = s_in;
                    if (tracking_reg) begin
                        ptr_next = (ptr_reg == LAST_IX) ? '0 : ptr_reg + 1'b1;
                        if (lo_ext < v_in && up_ext > v_in) begin
                            store_next[ptr_reg] = s_in;
                            taken_next = 1'b1;
                            state_next = ST_EMA1;
                        end else begin
                            taken_next = 1'b0;
                            state_next = ST_OUT;
                        end
                    end else begin
                        if (fill_reg >= DEPTH_C) begin
                            store_next[LAST_IX] = s_in;
                            fill_next = DEPTH_C;
                        end else begin
                            store_next[IW'(fill_reg)] = s_in;
                            fill_next = fill_reg + 1'b1;
                        end
                        taken_next = 1'b1;
                        state_next = ST_WM_MUL;
                    end
                end
            end
            ST_WM_MUL: begin
                if (mul_done) begin
                    tmp_next   = 64'({smp_reg, 8'b0}) + 64'(mul_prod);
                    state_next = ST_WM_DIV;
                end
            end
            ST_WM_DIV: begin
                if (ds_done) begin
                    mean_next = MW'(ds_res);
                    if (fill_reg == DEPTH_C) begin
                        sum_next   = '0;
                        idx_next   = '0;
                        state_next = ST_DEV_MUL;
                    end else begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_DEV_MUL: begin
                if (mul_done) begin
                    sum_next = sum_add[64] ? '1 : sum_add[63:0];
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg == LAST_IX) begin
                        idx_next   = '0;
                        state_next = ST_DEV_DIV;
                    end
                end
            end
            ST_DEV_DIV: begin
                if (ds_done) begin
                    tmp_next   = ds_res;
                    state_next = ST_DEV_SQRT;
                end
            end
            ST_DEV_SQRT: begin
                if (ds_done) begin
                    dev_next   = MW'(ds_res);
                    state_next = ST_LIM_MUL;
                end
            end
            ST_LIM_MUL: begin
                if (mul_done) begin
                    half_next  = sat_half({mul_prod, 8'b0});
                    state_next = tracking_reg ? ST_BAND_MUL : ST_LIM_SET;
                end
            end
            ST_BAND_MUL: begin
                if (mul_done) begin
                    if (bpart >= half_reg) begin
                        half_next = bpart;
                    end
                    state_next = ST_LIM_SET;
                end
            end
            ST_LIM_SET: begin
                lower_next = clamp_lim(lo_raw);
                upper_next = clamp_lim(hi_raw);
                idx_next   = '0;
                state_next = tracking_reg ? ST_OUT : ST_SCAN;
            end
            ST_SCAN: begin
                if (rd_out) begin
                    store_next[idx_reg] = '0;
                end
                fill_next = fill_sc;
                idx_next  = idx_reg + 1'b1;
                if (idx_reg == LAST_IX) begin
                    idx_next = '0;
                    acc_next = '0;
                    if (fill_sc == DEPTH_C) begin
                        tracking_next = 1'b1;
                        ptr_next      = '0;
                        state_next    = ST_OUT;
                    end else begin
                        state_next = ST_SUM;
                    end
                end
            end
            ST_SUM: begin
                if (fill_reg == '0) begin
                    mean_next  = '0;
                    state_next = ST_OUT;
                end else begin
                    acc_next = acc_reg + AC'(rd);
                    idx_next = idx_reg + 1'b1;
                    if (CW'(idx_reg) == fill_reg - 1'b1) begin
                        state_next = ST_REDIV;
                    end
                end
            end
            ST_REDIV: begin
                if (ds_done) begin
                    mean_next  = MW'(ds_res);
                    state_next = ST_OUT;
                end
            end
            ST_EMA1: begin
                if (mul_done) begin
                    tmp_next   = 64'(mul_prod);
                    state_next = ST_EMA2;
                end
            end
            ST_EMA2: begin
                if (mul_done) begin
                    mean_next  = MW'((tmp_reg + 64'(mul_prod)) >> 8);
                    sum_next   = '0;
                    idx_next   = '0;
                    state_next = ST_DEV_MUL;
                end
            end
            ST_OUT: begin
                if (!mvalid_reg || m_tready) begin
                    mvalid_next = 1'b1;
                    mmean_next  = 16'(mean_reg >> 8);
                    mtaken_next = taken_reg;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            for (int i = 0; i < DEPTH; i++) begin
                store_reg[i] <= '0;
            end
            fill_reg      <= '0;
            tracking_reg  <= 1'b0;
            ptr_reg       <= '0;
            mean_reg      <= '0;
            lower_reg     <= '0;
            upper_reg     <= '0;
            issued_reg    <= 1'b0;
            mvalid_reg    <= 1'b0;
            warm_mult_reg <= WARM_MULT_RST;
            run_mult_reg  <= RUN_MULT_RST;
            band_reg      <= BAND_FRACTION_RST;
            ema_reg       <= EMA_WEIGHT_RST;
        end else begin
            state_reg    <= state_next;
            store_reg    <= store_next;
            fill_reg     <= fill_next;
            tracking_reg <= tracking_next;
            ptr_reg      <= ptr_next;
            mean_reg     <= mean_next;
            lower_reg    <= lower_next;
            upper_reg    <= upper_next;
            issued_reg   <= issued_next;
            mvalid_reg   <= mvalid_next;
            if (cfg_we) begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_WARM_MULT:     warm_mult_reg <= cfg_wdata[3:0];
                    REG_RUN_MULT:      run_mult_reg  <= cfg_wdata[3:0];
                    REG_BAND_FRACTION: band_reg      <= cfg_wdata;
                    REG_EMA_WEIGHT:    ema_reg       <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        smp_reg    <= smp_next;
        taken_reg  <= taken_next;
        idx_reg    <= idx_next;
        sum_reg    <= sum_next;
        acc_reg    <= acc_next;
        tmp_reg    <= tmp_next;
        dev_reg    <= dev_next;
        half_reg   <= half_next;
        mmean_reg  <= mmean_next;
        mtaken_reg <= mtaken_next;
    end

    assign s_tready   = (state_reg == ST_IDLE);
    assign m_tvalid   = mvalid_reg;
    assign m_tdata    = mmean_reg;
    assign m_tuser[0] = mtaken_reg;

endmodule

### rtl/ormu_mul.sv
// ----------------------------------------------------------------------------
// ormu_mul
// Iterative multiplier: one MUL_DIGIT-bit digit of b per cycle, top digit first.
// ----------------------------------------------------------------------------
module ormu_mul import ormu_pkg::*; #(
    parameter int AW = 24,
    parameter int BW = 24
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [AW-1:0]      a,
    input  logic [BW-1:0]      b,
    output logic               done,
    output logic [AW+BW-1:0]   prod
);

    localparam int ND  = (BW + MUL_DIGIT - 1) / MUL_DIGIT;
    localparam int BPW = ND * MUL_DIGIT;
    localparam int PW  = AW + BW;
    localparam int CNW = (ND > 1) ? $clog2(ND) : 1;

    logic [AW-1:0]  a_reg;
    logic [BPW-1:0] b_reg;
    logic [PW-1:0]  acc_reg;
    logic [CNW-1:0] cnt_reg;
    logic           busy_reg;
    logic           done_reg;
    logic [AW+MUL_DIGIT-1:0] part;

    assign part = (AW+MUL_DIGIT)'(a_reg) * (AW+MUL_DIGIT)'(b_reg[BPW-1 -: MUL_DIGIT]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                a_reg    <= a;
                b_reg    <= BPW'(b);
                acc_reg  <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                acc_reg <= PW'(acc_reg << MUL_DIGIT) + PW'(part);
                b_reg   <= b_reg << MUL_DIGIT;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNW'(ND - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

### rtl/ormu_divsqrt.sv
// ----------------------------------------------------------------------------
// ormu_divsqrt
// Shared shift-subtract unit: restoring divide (one bit a cycle) or integer
// square root (two bits a cycle) of a DS_WIDTH-bit operand.
// ----------------------------------------------------------------------------
module ormu_divsqrt import ormu_pkg::*; #(
    parameter int DW = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  ds_ctl_t             ctl,
    input  logic [DS_WIDTH-1:0] x,
    input  logic [DW-1:0]       d,
    output logic                done,
    output logic [DS_WIDTH-1:0] res
);

    localparam int RW  = DS_WIDTH / 2 + 3;
    localparam int CNW = $clog2(DS_WIDTH);
    localparam logic [CNW-1:0] DIV_LAST  = CNW'(DS_WIDTH - 1);
    localparam logic [CNW-1:0] SQRT_LAST = CNW'(DS_WIDTH / 2 - 1);

    logic [DS_WIDTH-1:0] x_reg;
    logic [DS_WIDTH-1:0] res_reg;
    logic [DW-1:0]       d_reg;
    logic [RW-1:0]       rem_reg;
    logic [CNW-1:0]      cnt_reg;
    ds_mode_t            mode_reg;
    logic                busy_reg;
    logic                done_reg;

    logic [RW-1:0] rem_sh;
    logic [RW-1:0] trial;
    logic          ge;
    logic          last;

    always_comb begin
        if (mode_reg == DS_SQRT) begin
            rem_sh = {rem_reg[RW-3:0], x_reg[DS_WIDTH-1 -: 2]};
            trial  = {res_reg[RW-3:0], 2'b01};
            last   = (cnt_reg == SQRT_LAST);
        end else begin
            rem_sh = {rem_reg[RW-2:0], x_reg[DS_WIDTH-1]};
            trial  = RW'(d_reg);
            last   = (cnt_reg == DIV_LAST);
        end
        ge = (rem_sh >= trial);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            mode_reg <= DS_DIV;
        end else begin
            done_reg <= 1'b0;
            if (ctl.start) begin
                x_reg    <= x;
                d_reg    <= d;
                rem_reg  <= '0;
                res_reg  <= '0;
                cnt_reg  <= '0;
                mode_reg <= ctl.mode;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                x_reg   <= (mode_reg == DS_SQRT) ? (x_reg << 2) : (x_reg << 1);
                rem_reg <= ge ? (rem_sh - trial) : rem_sh;
                res_reg <= {res_reg[DS_WIDTH-2:0], ge};
                cnt_reg <= cnt_reg + 1'b1;
                if (last) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule
